>>> hw/rtl/k_way_sorted_run_merge_top_assert.svh
// Assertion macros for the run merge block.
`ifndef K_WAY_SORTED_RUN_MERGE_TOP_ASSERT_SVH
`define K_WAY_SORTED_RUN_MERGE_TOP_ASSERT_SVH

`define KWM_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

`define KWM_ASSERT_RESET(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("reset assertion failed");

`endif

>>> hw/rtl/kwm_pkg.sv
`default_nettype none
package kwm_pkg;
    localparam int MaxRecords  = 1024;
    localparam int MaxRuns     = 16;
    localparam int PayloadBits = 64;
    localparam int AddrW       = $clog2(MaxRecords);
    localparam int CntW        = $clog2(MaxRecords + 1);
    localparam int RunW        = $clog2(MaxRuns);
    localparam int RunCntW     = $clog2(MaxRuns + 1);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_PICK,
        ST_FETCH,
        ST_EMIT
    } kwm_state_t;

    typedef struct packed {
        logic [31:0]            freq;
        logic [PayloadBits-1:0] word;
    } kwm_rec_t;
endpackage
`default_nettype wire

>>> hw/rtl/k_way_sorted_run_merge_top.sv
// Channel   Dir  tdata (low bit up)                    tuser
// s_axis    in   rec_freq[31:0], rec_word[95:32]        req_type
// m_axis    out  out_freq[31:0], out_word[95:32]        out_empty
// A pop reads the head of each of the latched runs through the single read port
// of the record store, then picks, fetches and emits its result. The first pop
// of a batch also splits the loaded count with a divider and runs one setup step
// per run. Reset is synchronous and active low; the store contents are not
// cleared. A waiting result blocks the input until it is taken.
`default_nettype none
`include "k_way_sorted_run_merge_top_assert.svh"
module k_way_sorted_run_merge_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // rec_freq, rec_word
    input  wire logic        s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,  // out_freq, out_word
    output logic             m_axis_tlast,  // out_last
    output logic             m_axis_tuser   // out_empty
);
    import kwm_pkg::*;

    logic [4:0] chunk_reg;
    kwm_rec_t   in_rec, out_rec, wr_data, rd_data;
    logic       wr_en, merging;
    logic [AddrW-1:0] wr_addr, rd_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg <= 5'd1;
        end else if (cfg_wr_en) begin
            chunk_reg <= cfg_wr_data;
        end
    end

    assign in_rec = '{freq: s_axis_tdata[31:0], word: s_axis_tdata[32 +: PayloadBits]};
    assign m_axis_tdata = {out_rec.word, out_rec.freq};

    kwm_store u_store (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    kwm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .chunk_count(chunk_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_type(s_axis_tuser),
        .in_rec(in_rec), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_rec(out_rec), .out_last(m_axis_tlast), .out_empty(m_axis_tuser),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data), .rd_addr(rd_addr),
        .rd_data(rd_data), .merging(merging)
    );

    `KWM_ASSERT_IMPL(a_no_load_merge, aclk, aresetn, merging |-> !wr_en)
    `KWM_ASSERT_IMPL(a_empty_zero, aclk, aresetn,
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0 && !m_axis_tlast))
    `KWM_ASSERT_RESET(a_reset_idle, aclk, aresetn, !aresetn |=> !m_axis_tvalid)
endmodule
`default_nettype wire

>>> hw/rtl/kwm_store.sv
`default_nettype none
module kwm_store (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [kwm_pkg::AddrW-1:0] wr_addr,
    input  wire kwm_pkg::kwm_rec_t     wr_data,
    input  wire logic [kwm_pkg::AddrW-1:0] rd_addr,
    output kwm_pkg::kwm_rec_t          rd_data
);
    import kwm_pkg::*;

    kwm_rec_t mem [MaxRecords];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

>>> hw/rtl/kwm_ctrl.sv
`default_nettype none
module kwm_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [4:0]                 chunk_count,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       in_type,
    input  wire kwm_pkg::kwm_rec_t          in_rec,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output kwm_pkg::kwm_rec_t               out_rec,
    output logic                            out_last,
    output logic                            out_empty,
    output logic                            wr_en,
    output logic [kwm_pkg::AddrW-1:0]       wr_addr,
    output kwm_pkg::kwm_rec_t               wr_data,
    output logic [kwm_pkg::AddrW-1:0]       rd_addr,
    input  wire kwm_pkg::kwm_rec_t          rd_data,
    output logic                            merging
);
    import kwm_pkg::*;

    kwm_state_t state_reg, state_next;
    logic [CntW-1:0]    loaded_reg, loaded_next;
    logic [RunCntW-1:0] runs_reg, runs_next;
    logic [CntW-1:0]    head_reg [MaxRuns];
    logic [CntW-1:0]    end_reg  [MaxRuns];
    logic [MaxRuns-1:0] live_reg, live_next;
    logic [RunW-1:0]    idx_reg, idx_next;
    logic [RunW-1:0]    best_reg, best_next;
    logic [31:0]        bkey_reg, bkey_next;
    logic               found_reg, found_next;
    logic [CntW-1:0]    q_reg, q_next;
    logic [RunCntW-1:0] r_reg, r_next;
    logic [CntW-1:0]    start_reg, start_next;
    logic               merging_reg, merging_next;
    logic               ov_reg, ov_next;
    kwm_rec_t           orec_reg, orec_next;
    logic               olast_reg, olast_next;
    logic               oempty_reg, oempty_next;
    logic               pend_reg, pend_next;

    logic            acc;
    logic [CntW-1:0] seg_end;
    logic [CntW-1:0] new_head;
    logic [31:0]     cand_key;

    logic [CntW-1:0]    dq_reg;
    logic [RunCntW:0]   drem_reg;
    logic [$clog2(CntW+1)-1:0] dcnt_reg;
    logic               dbusy_reg;
    logic [RunCntW+1:0] dtrial;

    assign acc = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE) && !pend_reg && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign out_rec = orec_reg;
    assign out_last = olast_reg;
    assign out_empty = oempty_reg;
    assign merging = merging_reg;
    assign seg_end = start_reg + q_reg + ((CntW'(idx_reg) < CntW'(r_reg)) ? CntW'(1) : CntW'(0));
    assign new_head = head_reg[best_reg] + CntW'(1);
    assign cand_key = rd_data.freq ^ 32'h8000_0000;

    always_comb begin
        wr_en   = acc && (in_type == REQ_LOAD) && !merging_reg &&
                  (loaded_reg < CntW'(MaxRecords));
        wr_addr = loaded_reg[AddrW-1:0];
        wr_data = in_rec;
        rd_addr = (state_reg == ST_FETCH || state_reg == ST_EMIT) ?
                  head_reg[best_reg][AddrW-1:0] : head_reg[idx_reg][AddrW-1:0];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pend_reg) begin
                    if (merging_reg) begin
                        state_next = ST_SCAN;
                    end else if (!dbusy_reg) begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                if (idx_reg == RunW'(runs_reg - RunCntW'(1))) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == RunW'(runs_reg - RunCntW'(1))) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: state_next = ST_FETCH;
            ST_FETCH: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!ov_reg || out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        loaded_next = loaded_reg;
        runs_next = runs_reg;
        live_next = live_reg;
        idx_next = idx_reg;
        best_next = best_reg;
        bkey_next = bkey_reg;
        found_next = found_reg;
        q_next = q_reg;
        r_next = r_reg;
        start_next = start_reg;
        merging_next = merging_reg;
        ov_next = ov_reg && !out_ready;
        orec_next = orec_reg;
        olast_next = olast_reg;
        oempty_next = oempty_reg;
        pend_next = pend_reg;
        if (wr_en) begin
            loaded_next = loaded_reg + CntW'(1);
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (acc && in_type == REQ_POP) begin
                    if (!merging_reg && loaded_reg == '0) begin
                        ov_next = 1'b1;
                        orec_next = '0;
                        olast_next = 1'b0;
                        oempty_next = 1'b1;
                    end else begin
                        pend_next = 1'b1;
                        idx_next = '0;
                        found_next = 1'b0;
                        start_next = '0;
                        if (!merging_reg) begin
                            live_next = '0;
                            if (chunk_count == 5'd0) begin
                                runs_next = RunCntW'(1);
                            end else if (32'(chunk_count) > MaxRuns) begin
                                runs_next = RunCntW'(MaxRuns);
                            end else begin
                                runs_next = RunCntW'(chunk_count);
                            end
                        end
                    end
                end
                if (pend_reg && !merging_reg) begin
                    q_next = dq_reg;
                    r_next = drem_reg[RunCntW-1:0];
                end
            end
            ST_SETUP: begin
                start_next = seg_end;
                live_next[idx_reg] = (seg_end > start_reg);
                idx_next = idx_reg + RunW'(1);
                if (idx_reg == RunW'(runs_reg - RunCntW'(1))) begin
                    idx_next = '0;
                    merging_next = 1'b1;
                end
            end
            ST_SCAN: begin
                idx_next = idx_reg + RunW'(1);
            end
            ST_EMIT: begin
                if (!ov_reg || out_ready) begin
                    ov_next = 1'b1;
                    orec_next = rd_data;
                    oempty_next = 1'b0;
                    pend_next = 1'b0;
                    idx_next = '0;
                    found_next = 1'b0;
                    if (new_head >= end_reg[best_reg]) begin
                        live_next[best_reg] = 1'b0;
                    end
                    olast_next = (live_next == '0);
                    if (live_next == '0) begin
                        merging_next = 1'b0;
                        loaded_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // The scan pipeline compares the head read in the previous cycle.
    logic            cmp_v_reg;
    logic [RunW-1:0] cmp_i_reg;
    logic [RunW-1:0] best_s;
    logic [31:0]     bkey_s;
    logic            found_s;

    always_comb begin
        best_s = best_next;
        bkey_s = bkey_next;
        found_s = found_next;
        if (cmp_v_reg && live_reg[cmp_i_reg] && (!found_reg || cand_key < bkey_reg)) begin
            best_s = cmp_i_reg;
            bkey_s = cand_key;
            found_s = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            loaded_reg <= '0;
            runs_reg <= RunCntW'(1);
            live_reg <= '0;
            merging_reg <= 1'b0;
            ov_reg <= 1'b0;
            pend_reg <= 1'b0;
            found_reg <= 1'b0;
            cmp_v_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            loaded_reg <= loaded_next;
            runs_reg <= runs_next;
            live_reg <= live_next;
            merging_reg <= merging_next;
            ov_reg <= ov_next;
            pend_reg <= pend_next;
            idx_reg <= idx_next;
            cmp_v_reg <= (state_reg == ST_SCAN);
            if (state_reg == ST_SCAN || state_reg == ST_PICK) begin
                found_reg <= found_s;
            end else begin
                found_reg <= found_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_i_reg <= idx_reg;
        if (state_reg == ST_SCAN || state_reg == ST_PICK) begin
            best_reg <= best_s;
            bkey_reg <= bkey_s;
        end else begin
            best_reg <= best_next;
            bkey_reg <= bkey_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        start_reg <= start_next;
        orec_reg <= orec_next;
        olast_reg <= olast_next;
        oempty_reg <= oempty_next;
        if (state_reg == ST_SETUP) begin
            head_reg[idx_reg] <= start_reg;
            end_reg[idx_reg] <= seg_end;
        end else if (state_reg == ST_IDLE && pend_reg && !merging_reg) begin
            for (int i = 0; i < MaxRuns; i++) begin
                head_reg[i] <= '0;
                end_reg[i] <= '0;
            end
        end else if (state_reg == ST_EMIT && (!ov_reg || out_ready)) begin
            head_reg[best_reg] <= new_head;
        end
    end

    // Quotient and remainder of the split come from a shift-subtract divider.
    assign dtrial = {drem_reg, dq_reg[CntW-1]} - {1'b0, 1'b0, runs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg <= '0;
        end else if (acc && in_type == REQ_POP && !merging_reg && loaded_reg != '0) begin
            dbusy_reg <= 1'b1;
            dcnt_reg <= '0;
        end else if (dbusy_reg) begin
            dcnt_reg <= dcnt_reg + ($clog2(CntW+1))'(1);
            if (dcnt_reg == ($clog2(CntW+1))'(CntW - 1)) begin
                dbusy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && in_type == REQ_POP && !merging_reg) begin
            dq_reg <= loaded_reg;
            drem_reg <= '0;
        end else if (dbusy_reg) begin
            if (!dtrial[RunCntW+1]) begin
                drem_reg <= dtrial[RunCntW:0];
                dq_reg <= {dq_reg[CntW-2:0], 1'b1};
            end else begin
                drem_reg <= {drem_reg[RunCntW-1:0], dq_reg[CntW-1]};
                dq_reg <= {dq_reg[CntW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import kwm_pkg::*;

    typedef struct packed {
        logic        req;
        logic [31:0] freq;
        logic [63:0] word;
    } merge_req_t;

    typedef struct packed {
        logic [31:0] freq;
        logic [63:0] word;
        logic        last;
        logic        empty;
    } merge_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire [95:0]  m_axis_tdata;
    wire         m_axis_tlast;
    wire         m_axis_tuser;

    k_way_sorted_run_merge_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    merge_req_t  pending_reqs[$];
    merge_out_t  expected_recs[$];
    int          error_count = 0;
    int          pop_count = 0;
    int          empty_count = 0;
    int          batch_count = 0;
    int          queued = 0;
    bit          quiet_phase = 1'b0;
    int          send_gap = 0;
    int          recv_stall = 0;

    logic [31:0] key_mem[MaxRecords];
    logic [63:0] word_mem[MaxRecords];
    int          head[MaxRuns];
    int          run_stop[MaxRuns];
    logic [MaxRuns-1:0] live;
    int          loaded = 0;
    bit          merging = 1'b0;
    int          chunk_reg = 1;
    int          runs = 1;

    task automatic report(input string what, input logic [95:0] got, input logic [95:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic predict_merge(input merge_req_t r);
        int i;
        int start;
        int best;
        merge_out_t o;
        if (r.req == REQ_LOAD) begin
            if (!merging && loaded < MaxRecords) begin
                key_mem[loaded] = r.freq;
                word_mem[loaded] = r.word;
                loaded++;
            end
            return;
        end
        o = '0;
        if (!merging) begin
            if (loaded == 0) begin
                o.empty = 1'b1;
                expected_recs.push_back(o);
                return;
            end
            runs = (chunk_reg == 0) ? 1 : (chunk_reg > MaxRuns ? MaxRuns : chunk_reg);
            live = '0;
            start = 0;
            for (i = 0; i < runs; i++) begin
                run_stop[i] = (i + 1) * (loaded / runs)
                    + ((i + 1 < loaded % runs) ? i + 1 : loaded % runs);
                head[i] = start;
                if (run_stop[i] > start) live[i] = 1'b1;
                start = run_stop[i];
            end
            merging = 1'b1;
        end
        best = -1;
        for (i = 0; i < runs; i++) begin
            if (live[i] && (best < 0
                    || $signed(key_mem[head[i]]) < $signed(key_mem[head[best]]))) begin
                best = i;
            end
        end
        o.freq = key_mem[head[best]];
        o.word = word_mem[head[best]];
        head[best]++;
        if (head[best] >= run_stop[best]) live[best] = 1'b0;
        if (live == '0) begin
            o.last = 1'b1;
            merging = 1'b0;
            loaded = 0;
            batch_count++;
        end
        expected_recs.push_back(o);
    endtask

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_axis_tvalid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_reqs.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= pending_reqs[0].req;
                    s_axis_tdata <= {pending_reqs[0].word, pending_reqs[0].freq};
                    if (!quiet_phase && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 6);
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 5) == 0)
                    recv_stall <= $urandom_range(1, 6);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            predict_merge(pending_reqs.pop_front());
            s_axis_tvalid <= 1'b0;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_recs.size() == 0) begin
                report("unexpected item", m_axis_tdata, '0);
            end else begin
                merge_out_t e;
                e = expected_recs.pop_front();
                pop_count++;
                if (e.empty) empty_count++;
                if (m_axis_tdata[31:0] !== e.freq)
                    report("out_freq", m_axis_tdata[31:0], e.freq);
                if (m_axis_tdata[95:32] !== e.word)
                    report("out_word", m_axis_tdata[95:32], e.word);
                if (m_axis_tlast !== e.last) report("out_last", m_axis_tlast, e.last);
                if (m_axis_tuser !== e.empty) report("out_empty", m_axis_tuser, e.empty);
            end
        end
    end

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: rand_key = 32'h8000_0000;
            1: rand_key = 32'h7fff_ffff;
            2: rand_key = $urandom_range(0, 7) - 4;
            default: rand_key = $urandom;
        endcase
    endfunction

    task automatic add_item(input logic req, input logic [31:0] f, input logic [63:0] w);
        merge_req_t r;
        r.req = req;
        r.freq = f;
        r.word = w;
        pending_reqs.push_back(r);
        queued++;
    endtask

    task automatic add_batch(input int n, input int pops);
        int i;
        for (i = 0; i < n; i++) add_item(REQ_LOAD, rand_key(), {$urandom, $urandom});
        for (i = 0; i < pops; i++) add_item(REQ_POP, $urandom, {$urandom, $urandom});
    endtask

    task automatic drain_and_config(input int value);
        wait (pending_reqs.size() == 0 && expected_recs.size() == 0 && !s_axis_tvalid);
        repeat (40) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[4:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        chunk_reg = value;
    endtask

    initial begin
        int n;
        int pops;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Directed: pop on empty, extremes, ties, loads during merge.
        add_item(REQ_POP, '0, '0);
        add_item(REQ_LOAD, 32'h7fff_ffff, 64'hffff_ffff_ffff_ffff);
        add_item(REQ_LOAD, 32'h8000_0000, 64'h0);
        add_item(REQ_LOAD, 32'h0000_0005, 64'h1);
        add_item(REQ_LOAD, 32'h0000_0005, 64'h2);
        add_item(REQ_POP, '0, '0);
        add_item(REQ_LOAD, 32'h1234_5678, 64'hdead);
        add_item(REQ_POP, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
        add_item(REQ_POP, '0, '0);
        add_item(REQ_POP, '0, '0);
        add_item(REQ_POP, '0, '0);
        drain_and_config(0);
        add_batch(3, 4);
        drain_and_config(16);
        add_batch(5, 5);
        drain_and_config(31);
        add_batch(20, 20);
        drain_and_config(3);
        // Ties across runs with the store's stable ordering.
        for (n = 0; n < 6; n++) add_item(REQ_LOAD, 32'd7, 64'(n));
        for (n = 0; n < 6; n++) add_item(REQ_POP, '0, '0);
        while (queued < 560) begin
            drain_and_config($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                       : $urandom_range(1, 16));
            n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(4, 40);
            pops = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n + 2) : n;
            add_batch(n, pops);
            if (pops < n) begin
                add_batch(0, n - pops);
            end
        end
        // A config write in the middle of a merge must not change its runs.
        drain_and_config(4);
        add_batch(24, 10);
        drain_and_config(1);
        quiet_phase = 1'b1;
        add_batch(0, 14);
        add_item(REQ_POP, '0, '0);
        wait (pending_reqs.size() == 0 && expected_recs.size() == 0 && !s_axis_tvalid);
        repeat (40) @(posedge aclk);
        $display("Sent %0d items and checked %0d results over %0d merged batches.",
                 queued, pop_count, batch_count);
        $display("Empty pops seen: %0d.", empty_count);
        if (error_count == 0) begin
            $display("k_way_sorted_run_merge_top verification clean");
        end else begin
            $display("k_way_sorted_run_merge_top verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timed out with %0d items still expected.", expected_recs.size());
        $display("k_way_sorted_run_merge_top verification failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_store.sv
hw/rtl/kwm_ctrl.sv
hw/rtl/k_way_sorted_run_merge_top.sv
tb/testbench.sv
